FILE: rtl/core/rre_pkg.sv
// Shared types and constants for the rectangle region extremes block.
package rre_pkg;

   localparam int KIND_W = 2;
   localparam int ROW_W  = 6;
   localparam int COL_W  = 6;
   localparam int LEN_W  = 7;
   localparam int AREA_W = 13;
   localparam int CFG_W  = 7;
   localparam int NUM_RECS = 3;

   localparam logic [KIND_W-1:0] KIND_WIDEST  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TALLEST = 2'd1;
   localparam logic [KIND_W-1:0] KIND_AREA    = 2'd2;

   localparam logic REG_ROW_COUNT = 1'b0;
   localparam logic REG_COL_COUNT = 1'b1;

   localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [LEN_W-1:0]  width;
      logic [LEN_W-1:0]  height;
      logic [AREA_W-1:0] area;
   } rec_type;

   typedef struct packed {
      logic                   valid;
      rec_type [NUM_RECS-1:0] recs;
   } scan_res_type;

endpackage

FILE: rtl/core/rre_cell_mem.sv
// Single-bit cell store: one write port, one read port with registered data.
module rre_cell_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic mem [DEPTH];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/rre_scan.sv
// Scan sequencer: walks the stored grid, measures each corner and keeps the records.
module rre_scan #(
   parameter int MAX_DIM = 64
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic [$clog2(MAX_DIM+1)-1:0]                rows,
   input  logic [$clog2(MAX_DIM+1)-1:0]                cols,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]          rd_addr,
   input  logic                                        rd_data,
   output logic                                        idle,
   output rre_pkg::scan_res_type                       res,
   input  logic                                        res_ready
);
   import rre_pkg::*;

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int AW = $clog2(MAX_DIM * MAX_DIM);
   localparam int AR = 2 * DW;

   typedef enum logic [3:0] {
      S_IDLE, S_CELL_RD, S_CELL_CK, S_UP_RD, S_UP_CK, S_WID_RD, S_WID_CK,
      S_HGT_RD, S_HGT_CK, S_AREA, S_UPD, S_NEXT, S_DONE
   } state_type;

   typedef struct packed {
      logic [DW-1:0] row;
      logic [DW-1:0] col;
      logic [DW-1:0] width;
      logic [DW-1:0] height;
      logic [AR-1:0] area;
   } best_type;

   state_type     state_ff;
   logic [DW-1:0] rows_ff, cols_ff;
   logic [DW-1:0] r_ff, c_ff, k_ff, w_ff, h_ff;
   logic [AR-1:0] area_ff;
   logic [AW-1:0] row_base_ff, walk_addr_ff;
   logic          left_ff;
   best_type      best_ff [NUM_RECS];

   logic          wid_more, hgt_more, col_more, row_more;
   logic [AW-1:0] cell_addr;

   assign cell_addr = row_base_ff + AW'(c_ff);
   assign wid_more  = ((DW+1)'(k_ff) + (DW+1)'(1)) < (DW+1)'(cols_ff);
   assign hgt_more  = ((DW+1)'(k_ff) + (DW+1)'(1)) < (DW+1)'(rows_ff);
   assign col_more  = ((DW+1)'(c_ff) + (DW+1)'(1)) < (DW+1)'(cols_ff);
   assign row_more  = ((DW+1)'(r_ff) + (DW+1)'(1)) < (DW+1)'(rows_ff);

   always_comb begin
      case (state_ff)
         S_UP_RD:  rd_addr = cell_addr - AW'(cols_ff);
         S_WID_RD: rd_addr = row_base_ff + AW'(k_ff);
         S_HGT_RD: rd_addr = walk_addr_ff;
         default:  rd_addr = cell_addr;
      endcase
   end

   assign idle = (state_ff == S_IDLE);

   always_comb begin
      res.valid = (state_ff == S_DONE);
      for (int i = 0; i < NUM_RECS; i++) begin
         res.recs[i].row    = ROW_W'(best_ff[i].row);
         res.recs[i].col    = COL_W'(best_ff[i].col);
         res.recs[i].width  = LEN_W'(best_ff[i].width);
         res.recs[i].height = LEN_W'(best_ff[i].height);
         res.recs[i].area   = AREA_W'(best_ff[i].area);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  rows_ff     <= rows;
                  cols_ff     <= cols;
                  r_ff        <= '0;
                  c_ff        <= '0;
                  row_base_ff <= '0;
                  left_ff     <= 1'b0;
                  for (int i = 0; i < NUM_RECS; i++) begin
                     best_ff[i] <= '0;
                  end
                  state_ff <= S_CELL_RD;
               end
            end
            S_CELL_RD: state_ff <= S_CELL_CK;
            S_CELL_CK: begin
               left_ff <= rd_data;
               if (!rd_data || left_ff) begin
                  state_ff <= S_NEXT;
               end else if (r_ff != '0) begin
                  state_ff <= S_UP_RD;
               end else begin
                  k_ff     <= c_ff;
                  w_ff     <= '0;
                  state_ff <= S_WID_RD;
               end
            end
            S_UP_RD: state_ff <= S_UP_CK;
            S_UP_CK: begin
               if (rd_data) begin
                  state_ff <= S_NEXT;
               end else begin
                  k_ff     <= c_ff;
                  w_ff     <= '0;
                  state_ff <= S_WID_RD;
               end
            end
            S_WID_RD: state_ff <= S_WID_CK;
            S_WID_CK: begin
               if (rd_data && wid_more) begin
                  w_ff     <= w_ff + DW'(1);
                  k_ff     <= k_ff + DW'(1);
                  state_ff <= S_WID_RD;
               end else begin
                  // run ends: start the column walk at the corner
                  if (rd_data) begin
                     w_ff <= w_ff + DW'(1);
                  end
                  k_ff         <= r_ff;
                  h_ff         <= '0;
                  walk_addr_ff <= cell_addr;
                  state_ff     <= S_HGT_RD;
               end
            end
            S_HGT_RD: state_ff <= S_HGT_CK;
            S_HGT_CK: begin
               if (rd_data) begin
                  h_ff <= h_ff + DW'(1);
               end
               if (rd_data && hgt_more) begin
                  k_ff         <= k_ff + DW'(1);
                  walk_addr_ff <= walk_addr_ff + AW'(cols_ff);
                  state_ff     <= S_HGT_RD;
               end else begin
                  state_ff <= S_AREA;
               end
            end
            S_AREA: begin
               area_ff  <= AR'(w_ff) * AR'(h_ff);
               state_ff <= S_UPD;
            end
            S_UPD: begin
               if (w_ff > best_ff[KIND_WIDEST].width) begin
                  best_ff[KIND_WIDEST] <= '{r_ff, c_ff, w_ff, h_ff, area_ff};
               end
               if (h_ff > best_ff[KIND_TALLEST].height) begin
                  best_ff[KIND_TALLEST] <= '{r_ff, c_ff, w_ff, h_ff, area_ff};
               end
               if (area_ff > best_ff[KIND_AREA].area) begin
                  best_ff[KIND_AREA] <= '{r_ff, c_ff, w_ff, h_ff, area_ff};
               end
               state_ff <= S_NEXT;
            end
            S_NEXT: begin
               if (col_more) begin
                  c_ff     <= c_ff + DW'(1);
                  state_ff <= S_CELL_RD;
               end else begin
                  c_ff    <= '0;
                  left_ff <= 1'b0;
                  if (row_more) begin
                     r_ff        <= r_ff + DW'(1);
                     row_base_ff <= row_base_ff + AW'(cols_ff);
                     state_ff    <= S_CELL_RD;
                  end else begin
                     state_ff <= S_DONE;
                  end
               end
            end
            S_DONE: begin
               // hold the records until the output bank takes them
               if (res_ready) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/core/rectangle_region_extremes_top.sv
// Top level: configuration, grid loading, cell store, scan and record output.
// Cells stream in one word per cycle and are written straight into the cell
// store; the word flagged with tlast stores its cell and starts a scan of the
// grid, during which req_tready stays low. The scan runs through the single
// read port of the cell store, whose read data is registered: each cell is
// read and checked, and each top-left corner adds a read of its upper
// neighbor (none in the first row), a read of each cell on its rightward walk
// and on its downward walk (the run of ones plus the empty cell that ends it,
// unless the run reaches the grid edge) and the steps that form and rank the
// area. The records are then handed to the output bank; the hand-over waits
// while that bank still holds records of the previous grid. The three records
// (widest, tallest, largest area) then leave as three rsp words, the last
// flagged with tlast; loading of the next grid may proceed while they are
// still being taken.
module rectangle_region_extremes_top #(
   parameter int MAX_DIM = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   // config write port
   input  logic                      csr_we,
   input  logic                      csr_addr,
   input  logic [rre_pkg::CFG_W-1:0] csr_wdata,
   // input stream
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [7:0]                req_tdata,   // [0] cell_value
   input  logic                      req_tlast,   // is_final_cell
   // result stream
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [47:0]               rsp_tdata,   // [1:0] record_kind, [7:2] corner_row,
                                                  // [13:8] corner_col, [20:14] rect_width,
                                                  // [27:21] rect_height, [40:28] rect_area
   output logic                      rsp_tlast    // last_record
);
   import rre_pkg::*;

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int AW = $clog2(MAX_DIM * MAX_DIM);
   localparam int PW = $clog2(MAX_DIM * MAX_DIM + 1);
   localparam int CW = (DW > CFG_W) ? DW : CFG_W;

   logic [CFG_W-1:0] row_count_ff, col_count_ff;
   logic [PW-1:0]    load_pos_ff;
   logic [DW-1:0]    rows, cols;
   logic [2*DW-1:0]  total;
   logic             req_accept, store_en;

   logic [AW-1:0]    rd_addr;
   logic             rd_data;
   logic             scan_idle;
   scan_res_type     scan_res;

   rec_type [NUM_RECS-1:0] bank_ff;
   logic [KIND_W-1:0]      idx_ff;
   logic                   rsp_valid_ff;
   rec_type                cur_rec;

   // clamp the dimension registers into 1..MAX_DIM
   always_comb begin
      if (row_count_ff == '0) begin
         rows = DW'(1);
      end else if (CW'(row_count_ff) > CW'(MAX_DIM)) begin
         rows = DW'(MAX_DIM);
      end else begin
         rows = DW'(row_count_ff);
      end
      if (col_count_ff == '0) begin
         cols = DW'(1);
      end else if (CW'(col_count_ff) > CW'(MAX_DIM)) begin
         cols = DW'(MAX_DIM);
      end else begin
         cols = DW'(col_count_ff);
      end
   end

   assign total      = rows * cols;
   assign req_tready = scan_idle;
   assign req_accept = req_tvalid && req_tready;
   // drop cells past the end of the grid
   assign store_en   = req_accept && ((2*DW)'(load_pos_ff) < total);

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DIM_RESET;
         col_count_ff <= DIM_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            REG_ROW_COUNT: row_count_ff <= csr_wdata;
            REG_COL_COUNT: col_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_pos_ff <= '0;
      end else if (req_accept && req_tlast) begin
         load_pos_ff <= '0;
      end else if (store_en) begin
         load_pos_ff <= load_pos_ff + PW'(1);
      end
   end

   rre_cell_mem #(
      .DEPTH (MAX_DIM * MAX_DIM),
      .AW    (AW)
   ) u_cell_mem (
      .clock   (clock),
      .wr_en   (store_en),
      .wr_addr (load_pos_ff[AW-1:0]),
      .wr_data (req_tdata[0]),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rre_scan #(
      .MAX_DIM (MAX_DIM)
   ) u_scan (
      .clock     (clock),
      .reset     (reset),
      .start     (req_accept && req_tlast),
      .rows      (rows),
      .cols      (cols),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .idle      (scan_idle),
      .res       (scan_res),
      .res_ready (!rsp_valid_ff)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= KIND_WIDEST;
      end else if (!rsp_valid_ff) begin
         if (scan_res.valid) begin
            bank_ff      <= scan_res.recs;
            idx_ff       <= KIND_WIDEST;
            rsp_valid_ff <= 1'b1;
         end
      end else if (rsp_tready) begin
         // advance through the records, drop valid after the last one
         if (idx_ff == KIND_AREA) begin
            rsp_valid_ff <= 1'b0;
         end else begin
            idx_ff <= idx_ff + KIND_W'(1);
         end
      end
   end

   assign cur_rec    = bank_ff[idx_ff];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = (idx_ff == KIND_AREA);
   assign rsp_tdata  = {7'b0, cur_rec.area, cur_rec.height, cur_rec.width,
                        cur_rec.col, cur_rec.row, idx_ff};

endmodule
